[rtl/szfm_pkg.sv]
// Shared constants, types and codes for the sensor z-score fault monitor.
// No dependencies; every other file of the block imports this package.
package szfm_pkg;

   localparam int WINDOW_SIZE   = 60;
   localparam int SENSOR_COUNT  = 4;
   localparam int SAMPLE_BITS   = 16;
   localparam int MIN_HELD      = 10;
   localparam int DISC_MIN_HELD = 10;

   localparam int POS_W  = $clog2(WINDOW_SIZE);
   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + CNT_W;
   localparam int NQ_W   = SQ_W + CNT_W;
   localparam int S2_W   = 2 * SUM_W;
   localparam int VAR_W  = (NQ_W > S2_W) ? NQ_W : S2_W;
   localparam int DEV_W  = SAMPLE_BITS + CNT_W + 1;
   localparam int D2_W   = 2 * DEV_W + 4;
   localparam int ZW     = 12;
   localparam int KV_W   = ZW + VAR_W;
   localparam int CMP_W  = (KV_W > D2_W) ? KV_W : D2_W;
   localparam int RUN_W  = 6;
   localparam int DELTA_W = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_Z_WARN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SEVERE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_DELTA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_FLOOR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_MASK   = 3'd5;

   localparam logic [1:0] ALERT_NONE     = 2'd0;
   localparam logic [1:0] ALERT_INFO     = 2'd1;
   localparam logic [1:0] ALERT_WARNING  = 2'd2;
   localparam logic [1:0] ALERT_CRITICAL = 2'd3;

   typedef struct packed {
      logic [ZW-1:0]                 z_warn;
      logic [ZW-1:0]                 z_severe;
      logic [RUN_W-1:0]              stuck_limit;
      logic [DELTA_W-1:0]            stuck_delta;
      logic signed [SAMPLE_BITS-1:0] disc_floor;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } ctrl_type;

   typedef struct packed {
      logic outlier;
      logic new_outlier;
      logic severe;
      logic stuck;
      logic new_stuck;
      logic disc;
      logic new_disc;
   } lane_status_type;

endpackage

[rtl/szfm_lane.sv]
// One sensor lane: sample window memory, running sums, stuck and disconnect
// tracking and the staged outlier test. Depends on szfm_pkg.
module szfm_lane
   import szfm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_type                      ctrl,
   input  cfg_type                       cfg,
   input  logic                          disc_enable,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic [POS_W-1:0]              pos,
   input  logic [CNT_W-1:0]              held_before,
   input  logic [CNT_W-1:0]              held_after,
   output lane_status_type               status
);

   logic signed [SAMPLE_BITS-1:0] mem [WINDOW_SIZE];

   logic signed [SAMPLE_BITS-1:0] x_ff, old_ff, prev_ff;
   logic [2*SAMPLE_BITS-1:0]      xsq_ff, oldsq_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic [SQ_W-1:0]               sq_ff;
   logic [NQ_W-1:0]               nq_ff;
   logic [S2_W-1:0]               s2_ff;
   logic [DEV_W-1:0]              dev_ff;
   logic [VAR_W-1:0]              var_ff;
   logic [D2_W-1:0]               d2_ff;
   logic [KV_W-1:0]               pw_ff, ps_ff;
   logic [RUN_W-1:0]              run_ff;
   logic                          out_ff, new_out_ff, severe_ff;
   logic                          stuck_ff, new_stuck_ff, disc_ff, new_disc_ff;

   logic                          full;
   logic signed [SAMPLE_BITS-1:0] old_eff;
   logic signed [2*SAMPLE_BITS-1:0] xsq_c, oldsq_c;
   logic [NQ_W-1:0]               nq_c;
   logic [SUM_W-1:0]              sabs_c;
   logic [S2_W-1:0]               s2_c;
   logic signed [DEV_W-1:0]       nx_c, dv_c;
   logic [DEV_W-1:0]              adv_c;
   logic [VAR_W-1:0]              nq_x, s2_x;
   logic [2*DEV_W-1:0]            d2_c;
   logic [KV_W-1:0]               pw_c, ps_c;
   logic [CMP_W-1:0]              d2_x, pw_x, ps_x;
   logic                          disc_hit;
   logic signed [SAMPLE_BITS:0]   diff_c;
   logic [SAMPLE_BITS:0]          adiff_c;
   logic [RUN_W-1:0]              run_next;

   always_comb begin
      full     = (held_before >= CNT_W'(WINDOW_SIZE));
      old_eff  = full ? old_ff : '0;
      xsq_c    = x_ff * x_ff;
      oldsq_c  = old_eff * old_eff;
      nq_c     = held_after * sq_ff;
      sabs_c   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      s2_c     = sabs_c * sabs_c;
      nx_c     = $signed({1'b0, held_after}) * x_ff;
      dv_c     = nx_c - DEV_W'(sum_ff);
      adv_c    = dv_c[DEV_W-1] ? DEV_W'(-dv_c) : DEV_W'(dv_c);
      nq_x     = VAR_W'(nq_ff);
      s2_x     = VAR_W'(s2_ff);
      d2_c     = dev_ff * dev_ff;
      pw_c     = cfg.z_warn * var_ff;
      ps_c     = cfg.z_severe * var_ff;
      d2_x     = CMP_W'(d2_ff);
      pw_x     = CMP_W'(pw_ff);
      ps_x     = CMP_W'(ps_ff);
      disc_hit = disc_enable && (sample <= cfg.disc_floor) &&
                 (held_before > CNT_W'(DISC_MIN_HELD));
      diff_c   = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(prev_ff);
      adiff_c  = diff_c[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff_c)
                                     : (SAMPLE_BITS+1)'(diff_c);
      run_next = (run_ff < RUN_MAX) ? run_ff + 1'b1 : run_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         old_ff <= mem[pos];
      end
      if (ctrl.s1) begin
         mem[pos] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         x_ff <= sample;
      end
      if (ctrl.s1) begin
         xsq_ff   <= xsq_c;
         oldsq_ff <= oldsq_c;
      end
      if (ctrl.s3) begin
         nq_ff  <= nq_c;
         s2_ff  <= s2_c;
         dev_ff <= adv_c;
      end
      if (ctrl.s4) begin
         var_ff <= (nq_x > s2_x) ? nq_x - s2_x : '0;
         d2_ff  <= {d2_c, 4'b0000};
      end
      if (ctrl.s5) begin
         pw_ff <= pw_c;
         ps_ff <= ps_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sq_ff        <= '0;
         prev_ff      <= '0;
         run_ff       <= '0;
         out_ff       <= 1'b0;
         new_out_ff   <= 1'b0;
         severe_ff    <= 1'b0;
         stuck_ff     <= 1'b0;
         new_stuck_ff <= 1'b0;
         disc_ff      <= 1'b0;
         new_disc_ff  <= 1'b0;
      end else begin
         if (ctrl.accept) begin
            new_out_ff   <= 1'b0;
            severe_ff    <= 1'b0;
            new_stuck_ff <= !disc_hit && (adiff_c < (SAMPLE_BITS+1)'(cfg.stuck_delta)) &&
                            (run_next >= cfg.stuck_limit) && !stuck_ff;
            new_disc_ff  <= disc_hit && !disc_ff;
            if (disc_hit) begin
               disc_ff <= 1'b1;
            end else begin
               disc_ff <= 1'b0;
               prev_ff <= sample;
               if (adiff_c < (SAMPLE_BITS+1)'(cfg.stuck_delta)) begin
                  run_ff <= run_next;
                  if (run_next >= cfg.stuck_limit && !stuck_ff) begin
                     stuck_ff <= 1'b1;
                  end
               end else begin
                  run_ff   <= '0;
                  stuck_ff <= 1'b0;
               end
            end
         end
         if (ctrl.s2) begin
            sum_ff <= sum_ff - SUM_W'(old_eff) + SUM_W'(x_ff);
            sq_ff  <= sq_ff - SQ_W'(oldsq_ff) + SQ_W'(xsq_ff);
         end
         if (ctrl.s6 && held_after >= CNT_W'(MIN_HELD)) begin
            if (var_ff != '0 && d2_x > pw_x) begin
               if (!out_ff) begin
                  out_ff     <= 1'b1;
                  new_out_ff <= 1'b1;
                  severe_ff  <= (d2_x > ps_x);
               end
            end else begin
               out_ff <= 1'b0;
            end
         end
      end
   end

   assign status = '{outlier: out_ff, new_outlier: new_out_ff, severe: severe_ff,
                     stuck: stuck_ff, new_stuck: new_stuck_ff,
                     disc: disc_ff, new_disc: new_disc_ff};

endmodule

[rtl/sensor_zscore_fault_monitor.sv]
// Top level of the sensor z-score fault monitor: configuration registers,
// item sequencer, four sensor lanes and the merge of their flags.
// Depends on szfm_pkg and szfm_lane.
//
//   channel   ports                   direction  accepted when
//   request   req_valid/req_stall     in         req_valid && !req_stall
//   result    rsp_valid/rsp_stall     out        rsp_valid && !rsp_stall
//   config    csr_write_enable        in         csr_write_enable
//
// An item's result is registered once the lanes have stepped through window
// read, squaring, sum update, the N*Q and S*S products, the variance, the
// threshold products and the flag update, one stage each. A new item is
// taken the cycle after the result register loads, so a new item is never
// accepted while the previous one is in work.
// A stalled result holds the final step. Reset is synchronous and clears lane
// flags, sums, counters and the outlier total, not the result masks.
module sensor_zscore_fault_monitor
   import szfm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_air_temp,
   input  logic signed [SAMPLE_BITS-1:0] req_air_humidity,
   input  logic signed [SAMPLE_BITS-1:0] req_soil_moisture,
   input  logic signed [SAMPLE_BITS-1:0] req_light_level,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_alert_level,
   output logic [SENSOR_COUNT-1:0]       rsp_outlier_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_stuck_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_disconnected_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_new_outlier_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_severe_outlier_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_new_stuck_mask,
   output logic [SENSOR_COUNT-1:0]       rsp_new_disconnect_mask,
   output logic [31:0]                   rsp_outlier_total,
   input  logic                          csr_write_enable,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_write_data
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                 state_ff;
   logic [2:0]                step_ff;
   cfg_type                   cfg_ff;
   logic [SENSOR_COUNT-1:0]   disc_mask_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          fill_ff;
   logic [31:0]               total_ff;
   logic                      rsp_valid_ff;
   logic [1:0]                alert_ff;
   logic [SENSOR_COUNT-1:0]   out_m_ff, stuck_m_ff, disc_m_ff;
   logic [SENSOR_COUNT-1:0]   new_out_m_ff, severe_m_ff, new_stuck_m_ff, new_disc_m_ff;

   ctrl_type                      ctrl;
   logic                          emit;
   logic [CNT_W-1:0]              held_after;
   logic signed [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];
   lane_status_type               lane_st [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0]       out_m, stuck_m, disc_m, new_out_m;
   logic [SENSOR_COUNT-1:0]       severe_m, new_stuck_m, new_disc_m;
   logic [$clog2(SENSOR_COUNT+1)-1:0] new_count;
   logic [1:0]                    alert_in;

   assign samples[0] = req_air_temp;
   assign samples[1] = req_air_humidity;
   assign samples[2] = req_soil_moisture;
   assign samples[3] = req_light_level;

   assign req_stall  = (state_ff != ST_IDLE);
   assign emit       = (state_ff == ST_RUN) && (step_ff == 3'd7) &&
                       (!rsp_valid_ff || !rsp_stall);
   assign held_after = (fill_ff < CNT_W'(WINDOW_SIZE)) ? fill_ff + 1'b1
                                                       : CNT_W'(WINDOW_SIZE);

   always_comb begin
      ctrl.accept = req_valid && !req_stall;
      ctrl.s1     = (state_ff == ST_RUN) && (step_ff == 3'd1);
      ctrl.s2     = (state_ff == ST_RUN) && (step_ff == 3'd2);
      ctrl.s3     = (state_ff == ST_RUN) && (step_ff == 3'd3);
      ctrl.s4     = (state_ff == ST_RUN) && (step_ff == 3'd4);
      ctrl.s5     = (state_ff == ST_RUN) && (step_ff == 3'd5);
      ctrl.s6     = (state_ff == ST_RUN) && (step_ff == 3'd6);
   end

   genvar g;
   generate
      for (g = 0; g < SENSOR_COUNT; g++) begin : g_lane
         szfm_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .cfg         (cfg_ff),
            .disc_enable (disc_mask_ff[g]),
            .sample      (samples[g]),
            .pos         (pos_ff),
            .held_before (fill_ff),
            .held_after  (held_after),
            .status      (lane_st[g])
         );
         assign out_m[g]       = lane_st[g].outlier;
         assign new_out_m[g]   = lane_st[g].new_outlier;
         assign severe_m[g]    = lane_st[g].severe;
         assign stuck_m[g]     = lane_st[g].stuck;
         assign new_stuck_m[g] = lane_st[g].new_stuck;
         assign disc_m[g]      = lane_st[g].disc;
         assign new_disc_m[g]  = lane_st[g].new_disc;
      end
   endgenerate

   always_comb begin
      new_count = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         new_count = new_count + ($clog2(SENSOR_COUNT+1))'(new_out_m[i]);
      end
      if (disc_m != '0) begin
         alert_in = ALERT_CRITICAL;
      end else if (out_m != '0) begin
         alert_in = ALERT_WARNING;
      end else if (stuck_m != '0) begin
         alert_in = ALERT_INFO;
      end else begin
         alert_in = ALERT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.z_warn      <= ZW'(100);
         cfg_ff.z_severe    <= ZW'(196);
         cfg_ff.stuck_limit <= RUN_W'(30);
         cfg_ff.stuck_delta <= DELTA_W'(1);
         cfg_ff.disc_floor  <= '0;
         disc_mask_ff       <= SENSOR_COUNT'(7);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_Z_WARN:      cfg_ff.z_warn      <= csr_write_data[ZW-1:0];
            CSR_Z_SEVERE:    cfg_ff.z_severe    <= csr_write_data[ZW-1:0];
            CSR_STUCK_LIMIT: cfg_ff.stuck_limit <= csr_write_data[RUN_W-1:0];
            CSR_STUCK_DELTA: cfg_ff.stuck_delta <= csr_write_data[DELTA_W-1:0];
            CSR_DISC_FLOOR:  cfg_ff.disc_floor  <= $signed(csr_write_data[SAMPLE_BITS-1:0]);
            CSR_DISC_MASK:   disc_mask_ff       <= csr_write_data[SENSOR_COUNT-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (ctrl.accept) begin
                  state_ff <= ST_RUN;
                  step_ff  <= 3'd1;
               end
            end
            ST_RUN: begin
               if (step_ff != 3'd7) begin
                  step_ff <= step_ff + 1'b1;
               end else if (emit) begin
                  state_ff       <= ST_IDLE;
                  step_ff        <= '0;
                  alert_ff       <= alert_in;
                  out_m_ff       <= out_m;
                  stuck_m_ff     <= stuck_m;
                  disc_m_ff      <= disc_m;
                  new_out_m_ff   <= new_out_m;
                  severe_m_ff    <= severe_m;
                  new_stuck_m_ff <= new_stuck_m;
                  new_disc_m_ff  <= new_disc_m;
                  total_ff       <= total_ff + 32'(new_count);
                  fill_ff        <= held_after;
                  pos_ff         <= (pos_ff == POS_W'(WINDOW_SIZE - 1)) ? '0
                                                                        : pos_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_alert_level         = alert_ff;
   assign rsp_outlier_mask        = out_m_ff;
   assign rsp_stuck_mask          = stuck_m_ff;
   assign rsp_disconnected_mask   = disc_m_ff;
   assign rsp_new_outlier_mask    = new_out_m_ff;
   assign rsp_severe_outlier_mask = severe_m_ff;
   assign rsp_new_stuck_mask      = new_stuck_m_ff;
   assign rsp_new_disconnect_mask = new_disc_m_ff;
   assign rsp_outlier_total       = total_ff;

endmodule

[rtl/szfm_checker.sv]
// Port-level checks for the sensor z-score fault monitor, bound to the top.
// Depends on szfm_pkg.
module szfm_checker
   import szfm_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_alert_level,
   input logic [SENSOR_COUNT-1:0]       rsp_outlier_mask,
   input logic [SENSOR_COUNT-1:0]       rsp_disconnected_mask,
   input logic [SENSOR_COUNT-1:0]       rsp_new_outlier_mask,
   input logic [SENSOR_COUNT-1:0]       rsp_severe_outlier_mask
);

   ap_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   ap_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new item taken while one is in work");

   ap_critical_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_disconnected_mask != '0) == (rsp_alert_level == ALERT_CRITICAL)))
      else $error("alert level disagrees with disconnect mask");

   ap_new_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_new_outlier_mask & ~rsp_outlier_mask) == '0) &&
                     ((rsp_severe_outlier_mask & ~rsp_new_outlier_mask) == '0)))
      else $error("new or severe outlier bit without its flag");

endmodule

bind sensor_zscore_fault_monitor szfm_checker u_szfm_checker (.*);
